// File: design/ifts_pkg.sv
// ifts_pkg: shared codes and constants for the IPv4 flow traffic statistics block.
// No dependencies.
`timescale 1ns / 1ps
package ifts_pkg;

    localparam logic [1:0] CMD_FRAME    = 2'd0;
    localparam logic [1:0] CMD_INTERVAL = 2'd1;
    localparam logic [1:0] CMD_REPORT   = 2'd2;

    localparam logic [15:0] IPV4_TYPE = 16'h0800;
    localparam logic [15:0] MIN_COUNT_RESET = 16'd10;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_FLOW    = 1'b1;

    // x / 10 == (x * 52429) >> 19 for x below 43690
    localparam int          DIV10_SHIFT = 19;
    localparam logic [15:0] DIV10_MUL   = 16'd52429;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 264;

endpackage

// File: design/ipv4_flow_traffic_statistics.sv
// ipv4_flow_traffic_statistics: top level, command sequencer, counters and output register.
// Depends on ifts_pkg, ifts_ram and ifts_div10.
`timescale 1ns / 1ps
// One transaction is taken at a time; s_tready is high only while the sequencer idles.
// A frame transaction (IPv4 only) walks the sorted flow table, a read and a compare per
// entry checked, then a read and a write per entry shifted on an insert, as the flow
// memory has a single read port. A non-IPv4 frame and an interval transaction are
// handled in the accepting cycle without leaving idle. A report trims the interval
// series (a read and a check per entry examined), insertion sorts the remaining n byte
// counts in the sort memory (a read and a compare per step through its one read port),
// computes the three percentile indices in states IDX_A, IDX_B and IDX_C and reads them
// back one at a time, then emits one summary result and one result per flow, each held
// in an output register until m_tready takes it. Reports therefore run long; frames and
// interval ends are the fast path. No clearing pass follows reset.
module ipv4_flow_traffic_statistics #(
    parameter int SERIES_DEPTH = 256,
    parameter int FLOW_ENTRIES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config write: min_count
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [15:0]                         cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // ether_type[15:0], frame_length[31:16], src_addr[63:32], dst_addr[95:64]
    input  logic [ifts_pkg::IN_DATA_W-1:0]      s_tdata,
    // command[1:0]
    input  logic [1:0]                          s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // total_bytes[31:0], pct10_bytes[63:32], median_bytes[95:64], pct90_bytes[127:96],
    // stats_valid[128], dropped_flows[160:129], series_overflow[161],
    // flow_src[193:162], flow_dst[225:194], flow_bytes[257:226], zero pad[263:258]
    output logic [ifts_pkg::OUT_DATA_W-1:0]     m_tdata,
    // kind[0]
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import ifts_pkg::*;

    localparam int FAW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int FCW = $clog2(FLOW_ENTRIES + 1);
    localparam int SAW = (SERIES_DEPTH > 1) ? $clog2(SERIES_DEPTH) : 1;
    localparam int SCW = $clog2(SERIES_DEPTH + 1);
    localparam int XW  = SCW + 4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_F_RD, ST_F_CMP, ST_F_NEW, ST_F_SH, ST_F_SHW,
        ST_P_ST, ST_P_STC, ST_P_EN, ST_P_ENC,
        ST_S_V, ST_S_VG, ST_S_J, ST_S_JC,
        ST_IDX_A, ST_IDX_B, ST_IDX_C,
        ST_PR_RD, ST_PR_GET,
        ST_OUT_SUM, ST_OUT_FRD, ST_OUT_FGET, ST_OUT_W
    } state_t;

    state_t state_reg;

    logic [15:0]  min_count_reg;
    logic [31:0]  int_pk_reg, int_by_reg, total_reg, drop_reg;
    logic         ovf_reg, stats_valid_reg;
    logic [SCW-1:0] slen_reg;
    logic [FCW-1:0] used_reg;
    logic [31:0]  pct_reg [3];

    // working registers
    logic [63:0]  key_reg;
    logic [15:0]  len_reg;
    logic [FCW-1:0] pos_reg, k_reg, fi_reg;
    logic [SCW-1:0] start_reg, end_reg, n_reg, i_reg, j_reg;
    logic [31:0]  v_reg;
    logic [XW-1:0] q10_reg;
    logic [SCW-1:0] pidx_reg [3];
    logic [1:0]   p_reg;

    // output register
    logic         m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // memories
    logic         f_we, s_we, b_we;
    logic [FAW-1:0] f_waddr, f_raddr;
    logic [SAW-1:0] s_waddr, s_raddr, b_waddr, b_raddr;
    logic [95:0]  f_wdata, f_rdata;
    logic [63:0]  s_wdata, s_rdata;
    logic [31:0]  b_wdata, b_rdata;
    logic [XW-1:0] div_x, div_q;

    ifts_ram #(.DEPTH(FLOW_ENTRIES), .WIDTH(96), .AW(FAW)) u_flow_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    ifts_ram #(.DEPTH(SERIES_DEPTH), .WIDTH(64), .AW(SAW)) u_series_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    ifts_ram #(.DEPTH(SERIES_DEPTH), .WIDTH(32), .AW(SAW)) u_sort_ram (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    ifts_div10 #(.XW(XW)) u_div10 (
        .clk(clk), .x(div_x), .q(div_q)
    );

    logic s_acc;
    logic [1:0]  in_cmd;
    logic [15:0] in_etype, in_len;
    logic [31:0] in_src, in_dst;

    assign s_acc    = s_tvalid && s_tready;
    assign in_cmd   = s_tuser;
    assign in_etype = s_tdata[15:0];
    assign in_len   = s_tdata[31:16];
    assign in_src   = s_tdata[63:32];
    assign in_dst   = s_tdata[95:64];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    // flow table views
    logic [63:0] f_rkey;
    logic [31:0] f_rcnt;
    assign f_rkey = f_rdata[95:32];
    assign f_rcnt = f_rdata[31:0];

    // min_count threshold as a 32-bit value
    logic [31:0] min32;
    logic        s_pk_low;
    assign min32    = {16'd0, min_count_reg};
    assign s_pk_low = s_rdata[63:32] < min32;

    // percentile index arithmetic
    logic [XW-1:0] nx, nm1, t10, t50, t90, q90;
    logic          add1;
    assign nx   = XW'(n_reg);
    assign nm1  = nx - XW'(1);
    assign q90  = div_q;
    assign add1 = ((q10_reg << 3) + (q10_reg << 1)) != nx;
    assign t10  = q10_reg + XW'(add1);
    assign t50  = (nx >> 1) + XW'(add1);
    assign t90  = q90 + XW'(add1);

    // memory port control
    always_comb
    begin
        f_we    = 1'b0;
        f_waddr = pos_reg[FAW-1:0];
        f_wdata = {key_reg, f_rcnt + {16'd0, len_reg}};
        f_raddr = pos_reg[FAW-1:0];
        s_we    = 1'b0;
        s_waddr = slen_reg[SAW-1:0];
        s_wdata = {int_pk_reg, int_by_reg};
        s_raddr = start_reg[SAW-1:0];
        b_we    = 1'b0;
        b_waddr = j_reg[SAW-1:0];
        b_wdata = v_reg;
        b_raddr = pidx_reg[p_reg][SAW-1:0];
        div_x   = nx;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_we = s_acc && (in_cmd == CMD_INTERVAL) &&
                       (slen_reg < SCW'(SERIES_DEPTH));
            end
            ST_F_CMP:
            begin
                f_we = (f_rkey == key_reg);
            end
            ST_F_SH:
            begin
                f_raddr = FAW'(k_reg - FCW'(1));
                f_we    = !(k_reg > pos_reg);
                f_wdata = {key_reg, 16'd0, len_reg};
            end
            ST_F_SHW:
            begin
                f_we    = 1'b1;
                f_waddr = k_reg[FAW-1:0];
                f_wdata = f_rdata;
            end
            ST_P_EN:
            begin
                s_raddr = SAW'(end_reg - SCW'(1));
            end
            ST_S_V:
            begin
                s_raddr = SAW'(start_reg + i_reg);
            end
            ST_S_J:
            begin
                b_raddr = SAW'(j_reg - SCW'(1));
                b_we    = (j_reg == '0);
            end
            ST_S_JC:
            begin
                b_we    = 1'b1;
                b_wdata = (b_rdata > v_reg) ? b_rdata : v_reg;
            end
            ST_IDX_B:
            begin
                div_x = (nx << 3) + nx;
            end
            ST_OUT_FRD:
            begin
                f_raddr = fi_reg[FAW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            min_count_reg   <= MIN_COUNT_RESET;
            int_pk_reg      <= '0;
            int_by_reg      <= '0;
            total_reg       <= '0;
            drop_reg        <= '0;
            ovf_reg         <= 1'b0;
            stats_valid_reg <= 1'b0;
            slen_reg        <= '0;
            used_reg        <= '0;
            pct_reg[0]      <= '0;
            pct_reg[1]      <= '0;
            pct_reg[2]      <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                min_count_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        priority if (in_cmd == CMD_FRAME)
                        begin
                            if (in_etype == IPV4_TYPE)
                            begin
                                int_pk_reg <= int_pk_reg + 32'd1;
                                int_by_reg <= int_by_reg + {16'd0, in_len};
                                total_reg  <= total_reg + {16'd0, in_len};
                                key_reg    <= {in_src, in_dst};
                                len_reg    <= in_len;
                                pos_reg    <= '0;
                                state_reg  <= (used_reg == '0) ? ST_F_NEW : ST_F_RD;
                            end
                        end
                        else if (in_cmd == CMD_INTERVAL)
                        begin
                            if (slen_reg < SCW'(SERIES_DEPTH))
                            begin
                                slen_reg <= slen_reg + SCW'(1);
                            end
                            else
                            begin
                                ovf_reg <= 1'b1;
                            end
                            int_pk_reg <= '0;
                            int_by_reg <= '0;
                        end
                        else if (in_cmd == CMD_REPORT)
                        begin
                            start_reg <= '0;
                            state_reg <= ST_P_ST;
                        end
                    end
                end
                // flow table walk
                ST_F_RD:
                begin
                    state_reg <= ST_F_CMP;
                end
                ST_F_CMP:
                begin
                    priority if (f_rkey < key_reg)
                    begin
                        pos_reg   <= pos_reg + FCW'(1);
                        state_reg <= (pos_reg + FCW'(1) < used_reg) ? ST_F_RD : ST_F_NEW;
                    end
                    else if (f_rkey == key_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_F_NEW;
                    end
                end
                ST_F_NEW:
                begin
                    if (used_reg == FCW'(FLOW_ENTRIES))
                    begin
                        drop_reg  <= drop_reg + 32'd1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        k_reg     <= used_reg;
                        state_reg <= ST_F_SH;
                    end
                end
                ST_F_SH:
                begin
                    if (k_reg > pos_reg)
                    begin
                        state_reg <= ST_F_SHW;
                    end
                    else
                    begin
                        used_reg  <= used_reg + FCW'(1);
                        state_reg <= ST_IDLE;
                    end
                end
                ST_F_SHW:
                begin
                    k_reg     <= k_reg - FCW'(1);
                    state_reg <= ST_F_SH;
                end
                // trim warmup and cooldown
                ST_P_ST:
                begin
                    if (start_reg == slen_reg)
                    begin
                        stats_valid_reg <= 1'b0;
                        state_reg       <= ST_OUT_SUM;
                    end
                    else
                    begin
                        state_reg <= ST_P_STC;
                    end
                end
                ST_P_STC:
                begin
                    if (s_pk_low)
                    begin
                        start_reg <= start_reg + SCW'(1);
                        state_reg <= ST_P_ST;
                    end
                    else
                    begin
                        end_reg   <= slen_reg;
                        state_reg <= ST_P_EN;
                    end
                end
                ST_P_EN:
                begin
                    state_reg <= ST_P_ENC;
                end
                ST_P_ENC:
                begin
                    if (s_pk_low)
                    begin
                        end_reg   <= end_reg - SCW'(1);
                        state_reg <= ST_P_EN;
                    end
                    else
                    begin
                        n_reg     <= end_reg - start_reg;
                        i_reg     <= '0;
                        state_reg <= ST_S_V;
                    end
                end
                // insertion sort into the sort memory
                ST_S_V:
                begin
                    state_reg <= ST_S_VG;
                end
                ST_S_VG:
                begin
                    v_reg     <= s_rdata[31:0];
                    j_reg     <= i_reg;
                    state_reg <= ST_S_J;
                end
                ST_S_J, ST_S_JC:
                begin
                    priority if (state_reg == ST_S_J && j_reg != '0)
                    begin
                        state_reg <= ST_S_JC;
                    end
                    else if (state_reg == ST_S_JC && b_rdata > v_reg)
                    begin
                        j_reg     <= j_reg - SCW'(1);
                        state_reg <= ST_S_J;
                    end
                    else if (i_reg + SCW'(1) == n_reg)
                    begin
                        state_reg <= ST_IDX_A;
                    end
                    else
                    begin
                        i_reg     <= i_reg + SCW'(1);
                        state_reg <= ST_S_V;
                    end
                end
                // percentile indices
                ST_IDX_A:
                begin
                    state_reg <= ST_IDX_B;
                end
                ST_IDX_B:
                begin
                    q10_reg   <= div_q;
                    state_reg <= ST_IDX_C;
                end
                ST_IDX_C:
                begin
                    pidx_reg[0] <= SCW'((t10 > nm1) ? nm1 : t10);
                    pidx_reg[1] <= SCW'((t50 > nm1) ? nm1 : t50);
                    pidx_reg[2] <= SCW'((t90 > nm1) ? nm1 : t90);
                    p_reg       <= 2'd0;
                    state_reg   <= ST_PR_RD;
                end
                ST_PR_RD:
                begin
                    state_reg <= ST_PR_GET;
                end
                ST_PR_GET:
                begin
                    pct_reg[p_reg] <= b_rdata;
                    p_reg          <= p_reg + 2'd1;
                    if (p_reg == 2'd2)
                    begin
                        stats_valid_reg <= 1'b1;
                        state_reg       <= ST_OUT_SUM;
                    end
                    else
                    begin
                        state_reg <= ST_PR_RD;
                    end
                end
                // result emission
                ST_OUT_SUM:
                begin
                    m_tvalid_reg <= 1'b1;
                    m_tuser_reg  <= KIND_SUMMARY;
                    m_tlast_reg  <= (used_reg == '0);
                    m_tdata_reg  <= {6'd0, 96'd0, ovf_reg, drop_reg, stats_valid_reg,
                                     pct_reg[2], pct_reg[1], pct_reg[0], total_reg};
                    fi_reg       <= '0;
                    state_reg    <= ST_OUT_W;
                end
                ST_OUT_FRD:
                begin
                    state_reg <= ST_OUT_FGET;
                end
                ST_OUT_FGET:
                begin
                    m_tvalid_reg <= 1'b1;
                    m_tuser_reg  <= KIND_FLOW;
                    m_tlast_reg  <= (fi_reg + FCW'(1) == used_reg);
                    m_tdata_reg  <= {6'd0, f_rcnt, f_rkey[31:0], f_rkey[63:32], 162'd0};
                    fi_reg       <= fi_reg + FCW'(1);
                    state_reg    <= ST_OUT_W;
                end
                ST_OUT_W:
                begin
                    if (m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= m_tlast_reg ? ST_IDLE : ST_OUT_FRD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/ifts_ram.sv
// ifts_ram: simple dual-port memory, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps
module ifts_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ifts_div10.sv
// ifts_div10: registered divide-by-ten through a reciprocal multiply.
// Depends on ifts_pkg.
`timescale 1ns / 1ps
module ifts_div10 #(
    parameter int XW = 17
) (
    input  logic          clk,
    input  logic [XW-1:0] x,
    output logic [XW-1:0] q
);
    import ifts_pkg::*;

    logic [XW+15:0] prod;
    logic [XW-1:0]  q_reg;

    assign prod = x * (XW + 16)'(DIV10_MUL);

    always_ff @(posedge clk)
    begin
        q_reg <= XW'(prod >> DIV10_SHIFT);
    end

    assign q = q_reg;

endmodule

// File: tb/sv/testbench.sv
// testbench: self-checking bench for ipv4_flow_traffic_statistics.
// Depends on ifts_pkg and the design sources; predicts every result and checks each one.
`timescale 1ns / 1ps
module testbench;
    import ifts_pkg::*;

    localparam int SERIES_MAX = 256;
    localparam int FLOW_MAX   = 16;
    // cycles with no transaction anywhere before the run is declared hung;
    // a report over a full series, with its insertion sort, runs the longest
    localparam int HANG_LIMIT = 400000;
    // a frame walks and shifts the flow table after it is accepted
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic        kind;
        logic [31:0] total;
        logic [31:0] p10;
        logic [31:0] p50;
        logic [31:0] p90;
        logic        stats_ok;
        logic [31:0] dropped;
        logic        overflow;
        logic [31:0] fsrc;
        logic [31:0] fdst;
        logic [31:0] fbytes;
        logic        last;
    } stat_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [15:0]           cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // predictor state
    logic [15:0] mc_reg;
    logic [31:0] ivl_pkts, ivl_bytes, byte_total;
    logic [31:0] ser_pkts [SERIES_MAX];
    logic [31:0] ser_bytes[SERIES_MAX];
    int          ser_len;
    logic [63:0] flow_key [FLOW_MAX];
    logic [31:0] flow_cnt [FLOW_MAX];
    int          flow_len;
    logic [31:0] pct_reg [3];
    logic [31:0] drop_cnt;
    logic        ovf_flag;

    stat_result_t expected_results[$];

    int mismatch_count;
    int results_seen;
    int reports_sent;
    int frames_sent;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    int quiet_cycles;

    logic [31:0] pool_src[20];
    logic [31:0] pool_dst[20];

    ipv4_flow_traffic_statistics #(
        .SERIES_DEPTH(SERIES_MAX),
        .FLOW_ENTRIES(FLOW_MAX)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] pick_rank(logic [31:0] base, int n);
        logic [31:0] idx;
        begin
            idx = base + (((n % 10) != 0) ? 32'd1 : 32'd0);
            return (idx > 32'(n - 1)) ? 32'(n - 1) : idx;
        end
    endfunction

    // Updates the predicted state for one accepted transaction and queues its results.
    task automatic predict_transaction(logic [1:0] cmd, logic [15:0] etype,
                                       logic [15:0] len, logic [31:0] src,
                                       logic [31:0] dst);
        logic [63:0]  key;
        int           pos;
        int           first;
        int           stop;
        logic [31:0]  vals[$];
        logic         ok;
        stat_result_t r;
        begin
            key = {src, dst};
            if (cmd == CMD_FRAME && etype == IPV4_TYPE)
            begin
                ivl_pkts   += 1;
                ivl_bytes  += len;
                byte_total += len;
                pos = 0;
                while (pos < flow_len && flow_key[pos] < key)
                    pos++;
                if (pos < flow_len && flow_key[pos] == key)
                    flow_cnt[pos] += len;
                else if (flow_len >= FLOW_MAX)
                    drop_cnt += 1;
                else
                begin
                    for (int k = flow_len; k > pos; k--)
                    begin
                        flow_key[k] = flow_key[k-1];
                        flow_cnt[k] = flow_cnt[k-1];
                    end
                    flow_key[pos] = key;
                    flow_cnt[pos] = len;
                    flow_len++;
                end
            end
            else if (cmd == CMD_INTERVAL)
            begin
                if (ser_len < SERIES_MAX)
                begin
                    ser_pkts[ser_len]  = ivl_pkts;
                    ser_bytes[ser_len] = ivl_bytes;
                    ser_len++;
                end
                else
                    ovf_flag = 1'b1;
                ivl_pkts  = '0;
                ivl_bytes = '0;
            end
            else if (cmd == CMD_REPORT)
            begin
                // trim warmup and cooldown intervals
                first = 0;
                stop  = ser_len;
                while (first < ser_len && ser_pkts[first] < mc_reg)
                    first++;
                while (stop > first && ser_pkts[stop-1] < mc_reg)
                    stop--;
                ok = (stop > first);
                if (ok)
                begin
                    for (int i = first; i < stop; i++)
                        vals.push_back(ser_bytes[i]);
                    vals.sort();
                    pct_reg[0] = vals[pick_rank(vals.size() / 10, vals.size())];
                    pct_reg[1] = vals[pick_rank(vals.size() / 2, vals.size())];
                    pct_reg[2] = vals[pick_rank(vals.size() * 9 / 10, vals.size())];
                end
                r          = '0;
                r.kind     = KIND_SUMMARY;
                r.total    = byte_total;
                r.p10      = pct_reg[0];
                r.p50      = pct_reg[1];
                r.p90      = pct_reg[2];
                r.stats_ok = ok;
                r.dropped  = drop_cnt;
                r.overflow = ovf_flag;
                r.last     = (flow_len == 0);
                expected_results.push_back(r);
                for (int i = 0; i < flow_len; i++)
                begin
                    r        = '0;
                    r.kind   = KIND_FLOW;
                    r.fsrc   = flow_key[i][63:32];
                    r.fdst   = flow_key[i][31:0];
                    r.fbytes = flow_cnt[i];
                    r.last   = (i == flow_len - 1);
                    expected_results.push_back(r);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- driving

    // Offers one transaction; returns after it is accepted.
    task automatic send_item(logic [1:0] cmd, logic [15:0] etype, logic [15:0] len,
                             logic [31:0] src, logic [31:0] dst);
        int gap;
        begin
            gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tuser  = cmd;
            s_tdata  = {dst, src, len, etype};
            s_tvalid = 1'b1;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            predict_transaction(cmd, etype, len, src, dst);
            if (cmd == CMD_REPORT)
                reports_sent++;
            if (cmd == CMD_FRAME)
                frames_sent++;
            @(negedge clk);
            s_tvalid = 1'b0;
        end
    endtask

    task automatic send_frame(logic [15:0] len, logic [31:0] src, logic [31:0] dst);
        send_item(CMD_FRAME, IPV4_TYPE, len, src, dst);
    endtask

    task automatic send_cmd(logic [1:0] cmd);
        send_item(cmd, 16'($urandom), 16'($urandom), $urandom, $urandom);
    endtask

    task automatic wait_drained();
        begin
            while (expected_results.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // min_count is only written while the block is idle
    task automatic write_min_count(logic [15:0] value);
        begin
            wait_drained();
            cfg_data  = value;
            cfg_valid = 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            mc_reg = value;
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    // Random frame from the address pool, sometimes non-IPv4 or a fresh pair.
    task automatic send_random_frame();
        int          p;
        logic [15:0] et;
        begin
            p  = $urandom_range(19);
            et = ($urandom_range(9) == 0) ? 16'($urandom) : IPV4_TYPE;
            if ($urandom_range(15) == 0)
                send_item(CMD_FRAME, et, 16'($urandom), $urandom, $urandom);
            else
                send_item(CMD_FRAME, et, 16'($urandom), pool_src[p], pool_dst[p]);
        end
    endtask

    // ---------------------------------------------------------------- receiving

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready = 1'b0;
        else if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else
            m_tready = ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        begin
            $display("MISMATCH result %0d %s: got %h expected %h",
                     results_seen, what, got, want);
            mismatch_count++;
        end
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        stat_result_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", {31'd0, m_tuser}, 32'd0);
            else
            begin
                w = expected_results.pop_front();
                check_field("kind",            m_tuser,          w.kind);
                check_field("total_bytes",     m_tdata[31:0],    w.total);
                check_field("pct10_bytes",     m_tdata[63:32],   w.p10);
                check_field("median_bytes",    m_tdata[95:64],   w.p50);
                check_field("pct90_bytes",     m_tdata[127:96],  w.p90);
                check_field("stats_valid",     m_tdata[128],     w.stats_ok);
                check_field("dropped_flows",   m_tdata[160:129], w.dropped);
                check_field("series_overflow", m_tdata[161],     w.overflow);
                check_field("flow_src",        m_tdata[193:162], w.fsrc);
                check_field("flow_dst",        m_tdata[225:194], w.fdst);
                check_field("flow_bytes",      m_tdata[257:226], w.fbytes);
                check_field("last",            m_tlast,          w.last);
            end
            results_seen++;
        end
    end

    // watchdog: any transaction on any channel restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", HANG_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // empty report straight after reset: summary only, flagged last
    task automatic test_empty_report();
        send_cmd(CMD_REPORT);
    endtask

    task automatic test_directed_frames();
        begin
            send_frame(16'd0,     32'h0000_0000, 32'h0000_0000);
            send_frame(16'hFFFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_frame(16'd64,    32'hC0A8_0001, 32'h0A00_0001);
            send_frame(16'd1500,  32'hC0A8_0001, 32'h0A00_0001);
            send_frame(16'd100,   32'h0A00_0001, 32'hC0A8_0001);
            // non-IPv4 and unused command leave no trace
            send_item(CMD_FRAME, 16'h86DD, 16'd999, 32'h1, 32'h2);
            send_item(CMD_FRAME, 16'h0801, 16'd999, 32'h1, 32'h2);
            send_item(2'd3, IPV4_TYPE, 16'hFFFF, 32'h5, 32'h6);
            send_cmd(CMD_INTERVAL);
            send_frame(16'd60, 32'h0000_0000, 32'hFFFF_FFFF);
            send_cmd(CMD_INTERVAL);
            send_cmd(CMD_INTERVAL);
            // default min_count: no interval qualifies
            send_cmd(CMD_REPORT);
        end
    endtask

    task automatic test_min_count_sweep();
        begin
            write_min_count(16'd0);
            send_cmd(CMD_REPORT);
            write_min_count(16'd1);
            send_cmd(CMD_REPORT);
            write_min_count(16'hFFFF);
            send_cmd(CMD_REPORT);
            write_min_count(16'd2);
            send_cmd(CMD_REPORT);
            write_min_count(16'd3);
        end
    endtask

    // receiver holds off while frames keep coming behind a report
    task automatic test_backpressure();
        begin
            hold_left = 500;
            send_cmd(CMD_REPORT);
            repeat (6) send_random_frame();
        end
    endtask

    // sender pauses until everything queued has come out
    task automatic test_drain_pause();
        begin
            send_cmd(CMD_REPORT);
            while (expected_results.size() != 0)
                @(negedge clk);
            send_random_frame();
            send_cmd(CMD_REPORT);
        end
    endtask

    // mostly well-formed intervals of several frames, some noise
    task automatic test_random_traffic(int count);
        int sent;
        int r;
        begin
            sent = 0;
            while (sent < count)
            begin
                r = $urandom_range(99);
                if (r < 75)
                    send_random_frame();
                else if (r < 88)
                    send_cmd(CMD_INTERVAL);
                else if (r < 96)
                    send_cmd(CMD_REPORT);
                else
                    send_cmd(2'd3);
                sent++;
            end
            send_cmd(CMD_REPORT);
        end
    endtask

    // a batch of short intervals, then report at the current and the lowest threshold
    task automatic test_interval_tail();
        begin
            repeat (8)
            begin
                repeat ($urandom_range(0, 3)) send_random_frame();
                send_cmd(CMD_INTERVAL);
            end
            send_cmd(CMD_REPORT);
            write_min_count(16'd0);
            send_cmd(CMD_REPORT);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_FRAME;
        m_tready       = 1'b0;
        mismatch_count = 0;
        results_seen   = 0;
        reports_sent   = 0;
        frames_sent    = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        tx_idle_pct    = 35;
        rx_idle_pct    = 83;
        mc_reg         = MIN_COUNT_RESET;
        ivl_pkts       = '0;
        ivl_bytes      = '0;
        byte_total     = '0;
        ser_len        = 0;
        flow_len       = 0;
        drop_cnt       = '0;
        ovf_flag       = 1'b0;
        for (int i = 0; i < 3; i++)
            pct_reg[i] = '0;
        // every fourth pair shares the first destination
        for (int i = 0; i < 20; i++)
        begin
            pool_src[i] = $urandom;
            pool_dst[i] = (i % 4 == 0 && i > 0) ? pool_dst[0] : $urandom;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_report();
        test_directed_frames();
        test_min_count_sweep();
        test_backpressure();
        test_drain_pause();

        test_random_traffic(40);
        tx_idle_pct = 83;
        rx_idle_pct = 35;
        test_random_traffic(40);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(35);
        test_interval_tail();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("covered %0d frames, %0d reports, %0d results checked, %0d flows held",
                 frames_sent, reports_sent, results_seen, flow_len);
        $display("series filled to %0d with overflow %0b, %0d pairs dropped",
                 ser_len, ovf_flag, drop_cnt);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: files.f
design/ifts_pkg.sv
design/ifts_ram.sv
design/ifts_div10.sv
design/ipv4_flow_traffic_statistics.sv
tb/sv/testbench.sv
